>>> design/dtp_pkg.sv
// Shared types, constants and helper functions for the duration text parser.
// No dependencies; every other design file imports this package.
`default_nettype none

package dtp_pkg;

  localparam int DTP_QUEUE_DEPTH = 2;

  localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
  localparam logic [63:0] NS_PER_MIN  = NS_PER_SEC * 64'd60;
  localparam logic [63:0] NS_PER_HOUR = NS_PER_MIN * 64'd60;

  localparam logic [3:0] FRAC_LAST = 4'd9;

  typedef enum logic [3:0] {
    TK_BLANK  = 4'd0,
    TK_PLUS   = 4'd1,
    TK_MINUS  = 4'd2,
    TK_DIGIT  = 4'd3,
    TK_UNIT_H = 4'd4,
    TK_UNIT_M = 4'd5,
    TK_UNIT_S = 4'd6,
    TK_DOT    = 4'd7,
    TK_OTHER  = 4'd8,
    TK_END    = 4'd9
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [6:0] {
    PH_BETWEEN  = 7'b0000001,
    PH_SIGNED   = 7'b0000010,
    PH_DIGITS   = 7'b0000100,
    PH_AFTERNUM = 7'b0001000,
    PH_FRACTION = 7'b0010000,
    PH_FRACEND  = 7'b0100000,
    PH_ERROR    = 7'b1000000
  } phase_t;

  function automatic logic [26:0] frac_weight(input logic [3:0] place);
    logic [26:0] w;
    case (place)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] scaled_digit(input logic [3:0] d,
                                               input logic [63:0] unit_ns);
    return unit_ns * {60'd0, d};
  endfunction

  function automatic logic [63:0] times_ten(input logic [63:0] a);
    return (a << 3) + (a << 1);
  endfunction

endpackage

`default_nettype wire

>>> design/duration_text_parser.sv
// Duration text parser: one text byte per word in, one result per end word out.
// An accepted end word goes into the token queue; the parse engine pops it and
// registers the result and out_valid. Throughput: one word per cycle while
// in_ready is high; a result not yet taken holds the next end word at the queue
// head, and in_ready drops once the token queue fills behind it.
// Reset clears the parse state, the token queue and the output valid flag.
`default_nettype none

module duration_text_parser #(
  parameter int QUEUE_DEPTH = dtp_pkg::DTP_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_end_of_text,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_parse_ok,
  output logic signed [63:0] out_duration_ns
);
  import dtp_pkg::*;

  logic q_full;
  logic push;
  tok_t push_tok;
  logic head_valid;
  tok_t head_tok;
  logic pop;

  dtp_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .push           (push),
    .push_tok       (push_tok)
  );

  dtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop)
  );

  dtp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_tok        (head_tok),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_parse_ok    (out_parse_ok),
    .out_duration_ns (out_duration_ns)
  );

endmodule

`default_nettype wire

>>> design/dtp_front.sv
// Front end: takes input words and classifies each byte into a token.
// Depends on dtp_pkg; feeds dtp_queue.
`default_nettype none

module dtp_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_end_of_text,
  input  wire logic          q_full,
  output logic               push,
  output dtp_pkg::tok_t      push_tok
);
  import dtp_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_tok.digit = 4'd0;
    if (in_end_of_text) begin
      push_tok.kind = TK_END;
    end else begin
      case (in_char_code) inside
        8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C: push_tok.kind = TK_BLANK;
        8'h2B:                             push_tok.kind = TK_PLUS;
        8'h2D:                             push_tok.kind = TK_MINUS;
        [8'h30:8'h39]: begin
          push_tok.kind  = TK_DIGIT;
          push_tok.digit = in_char_code[3:0];
        end
        8'h68, 8'h48:                      push_tok.kind = TK_UNIT_H;
        8'h6D, 8'h4D:                      push_tok.kind = TK_UNIT_M;
        8'h73, 8'h53:                      push_tok.kind = TK_UNIT_S;
        8'h2E:                             push_tok.kind = TK_DOT;
        default:                           push_tok.kind = TK_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/dtp_queue.sv
// Short token queue between the classifier and the parse engine.
// Depends on dtp_pkg for the token type.
`default_nettype none

module dtp_queue #(
  parameter int DEPTH = dtp_pkg::DTP_QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  dtp_pkg::tok_t      push_tok,
  output logic               full,
  output logic               head_valid,
  output dtp_pkg::tok_t      head_tok,
  input  wire logic          pop
);
  import dtp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  tok_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/dtp_back.sv
// Parse engine: consumes tokens, keeps the term scaled per unit and the total.
// Depends on dtp_pkg; drives the registered result word.
`default_nettype none

module dtp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  dtp_pkg::tok_t      head_tok,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_parse_ok,
  output logic signed [63:0] out_duration_ns
);
  import dtp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_s_r, acc_s_nxt;
  logic [63:0] acc_m_r, acc_m_nxt;
  logic [63:0] acc_h_r, acc_h_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] total_r, total_nxt;
  logic        bare_min_r, bare_min_nxt;
  logic [3:0]  place_r, place_nxt;

  logic        out_valid_r;
  logic        out_ok_r;
  logic [63:0] out_dur_r;

  logic        is_end;
  logic [63:0] term_s, term_m, term_h;
  logic [63:0] dig_s, dig_m, dig_h;
  logic [63:0] frac_add;

  assign is_end = (head_tok.kind == TK_END);
  assign pop    = head_valid && (!is_end || !out_valid_r || out_ready);

  assign term_s = neg_r ? (64'd0 - acc_s_r) : acc_s_r;
  assign term_m = neg_r ? (64'd0 - acc_m_r) : acc_m_r;
  assign term_h = neg_r ? (64'd0 - acc_h_r) : acc_h_r;

  assign dig_s = scaled_digit(head_tok.digit, NS_PER_SEC);
  assign dig_m = scaled_digit(head_tok.digit, NS_PER_MIN);
  assign dig_h = scaled_digit(head_tok.digit, NS_PER_HOUR);

  assign frac_add = {33'd0, frac_weight(place_r) * {27'd0, head_tok.digit}};

  always_comb begin
    phase_nxt    = phase_r;
    acc_s_nxt    = acc_s_r;
    acc_m_nxt    = acc_m_r;
    acc_h_nxt    = acc_h_r;
    neg_nxt      = neg_r;
    total_nxt    = total_r;
    bare_min_nxt = bare_min_r;
    place_nxt    = place_r;
    if (is_end) begin
      phase_nxt    = PH_BETWEEN;
      acc_s_nxt    = '0;
      acc_m_nxt    = '0;
      acc_h_nxt    = '0;
      neg_nxt      = 1'b0;
      total_nxt    = '0;
      bare_min_nxt = 1'b0;
      place_nxt    = '0;
    end else begin
      case (phase_r)
        PH_BETWEEN: begin
          if (head_tok.kind == TK_PLUS || head_tok.kind == TK_MINUS) begin
            neg_nxt   = (head_tok.kind == TK_MINUS);
            phase_nxt = PH_SIGNED;
          end else if (head_tok.kind == TK_DIGIT) begin
            neg_nxt   = 1'b0;
            acc_s_nxt = dig_s;
            acc_m_nxt = dig_m;
            acc_h_nxt = dig_h;
            phase_nxt = PH_DIGITS;
          end else if (head_tok.kind != TK_BLANK) begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_SIGNED: begin
          if (head_tok.kind == TK_DIGIT) begin
            acc_s_nxt = dig_s;
            acc_m_nxt = dig_m;
            acc_h_nxt = dig_h;
            phase_nxt = PH_DIGITS;
          end else if (head_tok.kind != TK_BLANK) begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_DIGITS, PH_AFTERNUM: begin
          if (phase_r == PH_DIGITS && head_tok.kind == TK_DIGIT) begin
            acc_s_nxt = times_ten(acc_s_r) + dig_s;
            acc_m_nxt = times_ten(acc_m_r) + dig_m;
            acc_h_nxt = times_ten(acc_h_r) + dig_h;
          end else if (head_tok.kind == TK_BLANK) begin
            phase_nxt = PH_AFTERNUM;
          end else begin
            phase_nxt = PH_BETWEEN;
            case (head_tok.kind)
              TK_UNIT_H: begin
                total_nxt    = total_r + term_h;
                bare_min_nxt = 1'b1;
              end
              TK_UNIT_M: begin
                total_nxt    = total_r + term_m;
                bare_min_nxt = 1'b0;
              end
              TK_UNIT_S: begin
                total_nxt    = total_r + term_s;
                bare_min_nxt = 1'b0;
              end
              TK_DOT: begin
                total_nxt = total_r + term_s;
                place_nxt = '0;
                phase_nxt = PH_FRACTION;
              end
              default: begin
              end
            endcase
          end
        end
        PH_FRACTION, PH_FRACEND: begin
          if (phase_r == PH_FRACTION && head_tok.kind == TK_DIGIT) begin
            total_nxt = total_r + frac_add;
            if (place_r < FRAC_LAST) begin
              place_nxt = place_r + 4'd1;
            end
          end else if (head_tok.kind == TK_BLANK) begin
            phase_nxt = PH_FRACEND;
          end else if (head_tok.kind == TK_UNIT_S) begin
            bare_min_nxt = 1'b0;
            phase_nxt    = PH_BETWEEN;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        default: phase_nxt = PH_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BETWEEN;
      acc_s_r    <= '0;
      acc_m_r    <= '0;
      acc_h_r    <= '0;
      neg_r      <= 1'b0;
      total_r    <= '0;
      bare_min_r <= 1'b0;
      place_r    <= '0;
    end else if (pop) begin
      phase_r    <= phase_nxt;
      acc_s_r    <= acc_s_nxt;
      acc_m_r    <= acc_m_nxt;
      acc_h_r    <= acc_h_nxt;
      neg_r      <= neg_nxt;
      total_r    <= total_nxt;
      bare_min_r <= bare_min_nxt;
      place_r    <= place_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_end) begin
      case (phase_r)
        PH_DIGITS, PH_AFTERNUM: begin
          out_ok_r  <= 1'b1;
          out_dur_r <= total_r + (bare_min_r ? term_m : term_s);
        end
        PH_SIGNED, PH_ERROR: begin
          out_ok_r  <= 1'b0;
          out_dur_r <= '0;
        end
        default: begin
          out_ok_r  <= 1'b1;
          out_dur_r <= total_r;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_parse_ok    = out_ok_r;
  assign out_duration_ns = out_dur_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_end) |=> (phase_r == PH_BETWEEN && total_r == 64'd0 && !bare_min_r))
    else $error("parser state not cleared after end word");

  a_place_cap: assert property (@(posedge clk) disable iff (!rst_n)
    place_r <= FRAC_LAST)
    else $error("fraction place beyond last digit");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_dur_r == 64'd0))
    else $error("failed parse reports nonzero duration");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_dur_r) && $stable(out_ok_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
